// ===== sv/ppsg_pkg.sv =====
// Package for the price path step generator: fixed-point constants, register
// indexes, controller state and command/status types, reciprocal table.
// No dependencies.
package ppsg_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE          = 3'd0,
        REG_INITIAL_PRICE = 3'd1,
        REG_STEP_DRIFT    = 3'd2,
        REG_STEP_VOL      = 3'd3,
        REG_SQRT_STEP     = 3'd4
    } ppsg_reg_t;

    // Path modes
    localparam logic MODE_GEO   = 1'b0;
    localparam logic MODE_ARITH = 1'b1;

    // Fixed-point constants (Q30 unless noted)
    localparam logic [33:0] LOG2E_Q30   = 34'd1549082005;
    localparam logic [33:0] LN2_Q30     = 34'd744261118;
    localparam logic [31:0] ONE_Q30     = 32'h4000_0000;
    localparam int          X_LIMIT     = 134217728;   // exponent argument clamp, Q16.16
    localparam int          K_LIMIT     = 40;          // power-of-two exponent clamp
    localparam int          FRAC_SHIFT  = 30;          // binary point of the mantissa
    localparam logic [2:0]  SERIES_TERMS = 3'd7;

    // Half-LSB rounding terms (0.5 at each rounding position)
    localparam logic signed [67:0] HALF_Q12 = 68'sd2048;
    localparam logic signed [67:0] HALF_Q16 = 68'sd32768;
    localparam logic signed [67:0] HALF_Q30 = 68'sd536870912;

    // Configuration register bank
    typedef struct packed {
        logic               mode;
        logic [30:0]        initial_price;
        logic signed [31:0] step_drift;
        logic [30:0]        step_vol;
        logic [30:0]        sqrt_step;
    } ppsg_cfg_t;

    // Controller states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_VOLZ,
        ST_XSUM,
        ST_XMUL,
        ST_TSPLIT,
        ST_FMUL,
        ST_RSET,
        ST_MR,
        ST_QRND,
        ST_QREC,
        ST_MUPD,
        ST_PMUL,
        ST_SHIFT,
        ST_SZ,
        ST_ASUM,
        ST_DONE_RST,
        ST_DONE_ARI,
        ST_DONE_GEO
    } ppsg_state_t;

    // Shared multiplier operand selection
    typedef enum logic [2:0] {
        MUL_VOLZ,
        MUL_SQZ,
        MUL_XC,
        MUL_FC,
        MUL_MR,
        MUL_QN,
        MUL_PM
    } ppsg_mul_sel_t;

    // Result source
    typedef enum logic [1:0] {
        RES_RESTART,
        RES_ARITH,
        RES_GEO
    } ppsg_res_sel_t;

    typedef struct packed {
        logic          capture;
        logic          mul_en;
        ppsg_mul_sel_t mul_sel;
        logic          ld_x;
        logic          ld_tk;
        logic          ld_r;
        logic          ld_q;
        logic          ld_m;
        logic          ld_sum;
        logic          ld_shift;
        logic          ld_out;
        ppsg_res_sel_t res_sel;
    } ppsg_cmd_t;

    typedef struct packed {
        logic mode;
        logic n_last;
        logic out_free;
    } ppsg_stat_t;

    // floor(2^32 / n) for the series divisors 1..7
    function automatic logic [32:0] ppsg_recip(input logic [2:0] n);
        logic [32:0] r;
        case (n)
            3'd1:    r = 33'h1_0000_0000;
            3'd2:    r = 33'd2147483648;
            3'd3:    r = 33'd1431655765;
            3'd4:    r = 33'd1073741824;
            3'd5:    r = 33'd858993459;
            3'd6:    r = 33'd715827882;
            3'd7:    r = 33'd613566756;
            default: r = 33'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/ppsg_if.sv =====
// Channel interfaces of the price path step generator: sample input,
// result output and configuration write.
// Depends on ppsg_pkg.
interface ppsg_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] z_sample;
    logic               restart;

    modport source (output valid, output z_sample, output restart, input ready);
    modport sink   (input valid, input z_sample, input restart, output ready);
endinterface

interface ppsg_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] price;
    logic               saturated;

    modport source (output valid, output price, output saturated, input ready);
    modport sink   (input valid, input price, input saturated, output ready);
endinterface

interface ppsg_cfg_if;
    import ppsg_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/ppsg_cfg.sv =====
// Configuration register bank of the price path step generator.
// Depends on ppsg_pkg and ppsg_cfg_if.
module ppsg_cfg (
    input  logic               clk,
    input  logic               rst_n,
    ppsg_cfg_if.sink           cfg,
    output ppsg_pkg::ppsg_cfg_t cfg_q
);
    import ppsg_pkg::*;

    ppsg_cfg_t cfg_reg;
    ppsg_cfg_t cfg_next;

    // Writes are always taken
    assign cfg.ready = 1'b1;
    assign cfg_q     = cfg_reg;

    // Register decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (ppsg_reg_t'(cfg.index))
                REG_MODE:          cfg_next.mode          = cfg.data[0];
                REG_INITIAL_PRICE: cfg_next.initial_price = cfg.data[30:0];
                REG_STEP_DRIFT:    cfg_next.step_drift    = cfg.data;
                REG_STEP_VOL:      cfg_next.step_vol      = cfg.data[30:0];
                REG_SQRT_STEP:     cfg_next.sqrt_step     = cfg.data[30:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode          <= MODE_GEO;
            cfg_reg.initial_price <= 31'd65536;
            cfg_reg.step_drift    <= 32'sd0;
            cfg_reg.step_vol      <= 31'd0;
            cfg_reg.sqrt_step     <= 31'd65536;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== sv/ppsg_ctrl.sv =====
// Controller of the price path step generator: sequences the shared
// multiplier and datapath loads for one item at a time.
// Depends on ppsg_pkg.
module ppsg_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_restart,
    output logic                 in_ready,
    input  ppsg_pkg::ppsg_stat_t stat,
    output ppsg_pkg::ppsg_cmd_t  cmd
);
    import ppsg_pkg::*;

    ppsg_state_t state_reg;
    ppsg_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_restart)
                        state_next = ST_DONE_RST;
                    else if (stat.mode == MODE_ARITH)
                        state_next = ST_SZ;
                    else
                        state_next = ST_VOLZ;
                end
            end
            ST_VOLZ:     state_next = ST_XSUM;
            ST_XSUM:     state_next = ST_XMUL;
            ST_XMUL:     state_next = ST_TSPLIT;
            ST_TSPLIT:   state_next = ST_FMUL;
            ST_FMUL:     state_next = ST_RSET;
            ST_RSET:     state_next = ST_MR;
            ST_MR:       state_next = ST_QRND;
            ST_QRND:     state_next = ST_QREC;
            ST_QREC:     state_next = ST_MUPD;
            ST_MUPD:     state_next = stat.n_last ? ST_PMUL : ST_MR;
            ST_PMUL:     state_next = ST_SHIFT;
            ST_SHIFT:    state_next = ST_DONE_GEO;
            ST_SZ:       state_next = ST_ASUM;
            ST_ASUM:     state_next = ST_DONE_ARI;
            ST_DONE_RST,
            ST_DONE_ARI,
            ST_DONE_GEO: state_next = stat.out_free ? ST_IDLE : state_reg;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Command outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_VOLZ:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_VOLZ;
            end
            ST_XSUM:     cmd.ld_x = 1'b1;
            ST_XMUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_XC;
            end
            ST_TSPLIT:   cmd.ld_tk = 1'b1;
            ST_FMUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_FC;
            end
            ST_RSET:     cmd.ld_r = 1'b1;
            ST_MR:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_MR;
            end
            ST_QRND:     cmd.ld_q = 1'b1;
            ST_QREC:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_QN;
            end
            ST_MUPD:     cmd.ld_m = 1'b1;
            ST_PMUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_PM;
            end
            ST_SHIFT:    cmd.ld_shift = 1'b1;
            ST_SZ:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SQZ;
            end
            ST_ASUM:     cmd.ld_sum = 1'b1;
            ST_DONE_RST:
            begin
                cmd.ld_out  = stat.out_free;
                cmd.res_sel = RES_RESTART;
            end
            ST_DONE_ARI:
            begin
                cmd.ld_out  = stat.out_free;
                cmd.res_sel = RES_ARITH;
            end
            ST_DONE_GEO:
            begin
                cmd.ld_out  = stat.out_free;
                cmd.res_sel = RES_GEO;
            end
            default:     cmd = '0;
        endcase
    end

endmodule

// ===== sv/ppsg_dp.sv =====
// Datapath of the price path step generator: shared 34x34 multiplier,
// exponent argument, series mantissa, scaling, clipping and output register.
// Depends on ppsg_pkg and ppsg_out_if.
module ppsg_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ppsg_pkg::ppsg_cfg_t  cfg_q,
    input  logic signed [15:0]   z_sample,
    input  ppsg_pkg::ppsg_cmd_t  cmd,
    output ppsg_pkg::ppsg_stat_t stat,
    ppsg_out_if.source           result
);
    import ppsg_pkg::*;

    // Item and working registers
    logic signed [15:0] z_reg;
    logic               neg_reg;
    logic [31:0]        mag_reg;
    logic signed [67:0] prod_reg;
    logic signed [28:0] x_reg;
    logic [15:0]        f_reg;
    logic signed [7:0]  s_reg;
    logic [29:0]        r_reg;
    logic [31:0]        m_reg;
    logic [2:0]         n_reg;
    logic [31:0]        q_reg;
    logic signed [36:0] sum_reg;
    logic [71:0]        res_reg;
    logic signed [31:0] cur_price_reg;
    logic signed [31:0] price_out_reg;
    logic               sat_out_reg;
    logic               out_valid_reg;

    logic [31:0]        mag_next;
    logic signed [33:0] mul_a;
    logic signed [33:0] mul_b;
    logic signed [67:0] prod_next;
    logic signed [67:0] rnd12_sum;
    logic signed [35:0] rnd12;
    logic signed [36:0] x_full;
    logic signed [28:0] x_next;
    logic signed [67:0] t_sum;
    logic signed [29:0] t_val;
    logic signed [13:0] k_val;
    logic signed [7:0]  k_clamp;
    logic signed [7:0]  s_next;
    logic [15:0]        f_next;
    logic signed [67:0] r_sum;
    logic [29:0]        r_next;
    logic signed [67:0] q_sum;
    logic [31:0]        q_next;
    logic [31:0]        qe;
    logic [34:0]        qn;
    logic [34:0]        rem;
    logic [31:0]        m_next;
    logic signed [36:0] sum_next;
    logic [71:0]        p_wide;
    logic [6:0]         rshift;
    logic signed [7:0]  neg_s;
    logic [3:0]         lshift;
    logic [71:0]        rnd_bit;
    logic [71:0]        res_next;
    logic [31:0]        lim;
    logic               geo_sat;
    logic [31:0]        geo_mag;
    logic signed [31:0] res_price;
    logic               res_sat;

    // Status to the controller
    assign stat.mode     = cfg_q.mode;
    assign stat.n_last   = (n_reg == 3'd1);
    assign stat.out_free = !out_valid_reg || result.ready;

    assign result.valid     = out_valid_reg;
    assign result.price     = price_out_reg;
    assign result.saturated = sat_out_reg;

    // Magnitude of the stored price; the sign is kept aside
    assign mag_next = cur_price_reg[31] ? 32'(-cur_price_reg) : 32'(cur_price_reg);

    // Shared multiplier operand selection
    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_VOLZ:
            begin
                mul_a = {3'b000, cfg_q.step_vol};
                mul_b = {{18{z_reg[15]}}, z_reg};
            end
            MUL_SQZ:
            begin
                mul_a = {3'b000, cfg_q.sqrt_step};
                mul_b = {{18{z_reg[15]}}, z_reg};
            end
            MUL_XC:
            begin
                mul_a = {{5{x_reg[28]}}, x_reg};
                mul_b = LOG2E_Q30;
            end
            MUL_FC:
            begin
                mul_a = {18'd0, f_reg};
                mul_b = LN2_Q30;
            end
            MUL_MR:
            begin
                mul_a = {2'b00, m_reg};
                mul_b = {4'd0, r_reg};
            end
            MUL_QN:
            begin
                mul_a = {2'b00, q_reg};
                mul_b = {1'b0, ppsg_recip(n_reg)};
            end
            MUL_PM:
            begin
                mul_a = {2'b00, mag_reg};
                mul_b = {2'b00, m_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // Q.28 product rounded half up to Q16.16
    assign rnd12_sum = prod_reg + HALF_Q12;
    assign rnd12     = rnd12_sum[47:12];

    // Exponent argument, clamped
    assign x_full = {{5{cfg_q.step_drift[31]}}, cfg_q.step_drift} + {rnd12[35], rnd12};

    always_comb
    begin
        if (x_full > 37'(X_LIMIT))
            x_next = 29'(X_LIMIT);
        else if (x_full < -37'(X_LIMIT))
            x_next = -29'(X_LIMIT);
        else
            x_next = x_full[28:0];
    end

    // x / ln2 split into integer exponent k and fraction f
    assign t_sum  = prod_reg + HALF_Q30;
    assign t_val  = t_sum[59:30];
    assign k_val  = t_val[29:16];
    assign f_next = t_val[15:0];

    always_comb
    begin
        if (k_val > 14'(K_LIMIT))
            k_clamp = 8'(K_LIMIT);
        else if (k_val < -14'(K_LIMIT))
            k_clamp = -8'(K_LIMIT);
        else
            k_clamp = k_val[7:0];
    end

    assign s_next = 8'(FRAC_SHIFT) - k_clamp;

    // r = f * ln2 in Q30
    assign r_sum  = prod_reg + HALF_Q16;
    assign r_next = r_sum[45:16];

    // Series term: q = round(m * r), then q / n by reciprocal with one correction
    assign q_sum  = prod_reg + HALF_Q30;
    assign q_next = q_sum[61:30];
    assign qe     = prod_reg[63:32];
    assign qn     = 35'(qe) * 35'(n_reg);
    assign rem    = 35'(q_reg) - qn;
    assign m_next = ONE_Q30 + qe + 32'((rem >= 35'(n_reg)) ? 1 : 0);

    // Arithmetic step sum
    assign sum_next = {{5{cur_price_reg[31]}}, cur_price_reg} + {rnd12[35], rnd12};

    // Scale the Q46 product by 2^(k-30), rounding half up on right shifts
    assign p_wide  = {8'd0, prod_reg[63:0]};
    assign rshift  = s_reg[6:0];
    assign neg_s   = -s_reg;
    assign lshift  = neg_s[3:0];
    assign rnd_bit = 72'd1 << (rshift - 7'd1);

    always_comb
    begin
        if (s_reg > 8'sd0)
            res_next = (p_wide + rnd_bit) >> rshift;
        else
            res_next = p_wide << lshift;
    end

    // Geometric result: clip magnitude, restore sign
    assign lim       = neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    assign geo_sat   = res_reg > {40'd0, lim};
    assign geo_mag   = geo_sat ? lim : res_reg[31:0];

    // Result select
    always_comb
    begin
        unique case (cmd.res_sel)
            RES_RESTART:
            begin
                res_price = (cfg_q.mode == MODE_ARITH) ? 32'sd0 : {1'b0, cfg_q.initial_price};
                res_sat   = 1'b0;
            end
            RES_ARITH:
            begin
                if (sum_reg > 37'sd2147483647)
                begin
                    res_price = 32'h7FFF_FFFF;
                    res_sat   = 1'b1;
                end
                else if (sum_reg < -37'sd2147483648)
                begin
                    res_price = 32'h8000_0000;
                    res_sat   = 1'b1;
                end
                else
                begin
                    res_price = sum_reg[31:0];
                    res_sat   = 1'b0;
                end
            end
            RES_GEO:
            begin
                res_price = neg_reg ? 32'(-geo_mag) : geo_mag;
                res_sat   = geo_sat;
            end
            default:
            begin
                res_price = 32'sd0;
                res_sat   = 1'b0;
            end
        endcase
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            z_reg   <= z_sample;
            neg_reg <= cur_price_reg[31];
            mag_reg <= mag_next;
        end
        if (cmd.mul_en)
            prod_reg <= prod_next;
        if (cmd.ld_x)
            x_reg <= x_next;
        if (cmd.ld_tk)
        begin
            f_reg <= f_next;
            s_reg <= s_next;
        end
        if (cmd.ld_r)
        begin
            r_reg <= r_next;
            m_reg <= ONE_Q30;
            n_reg <= SERIES_TERMS;
        end
        if (cmd.ld_q)
            q_reg <= q_next;
        if (cmd.ld_m)
        begin
            m_reg <= m_next;
            n_reg <= n_reg - 3'd1;
        end
        if (cmd.ld_sum)
            sum_reg <= sum_next;
        if (cmd.ld_shift)
            res_reg <= res_next;
        if (cmd.ld_out)
        begin
            price_out_reg <= res_price;
            sat_out_reg   <= res_sat;
        end
    end

    // Path state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_price_reg <= 32'sd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ld_out)
                cur_price_reg <= res_price;
            if (cmd.ld_out)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

// ===== sv/price_path_step_generator_top.sv =====
// Top level of the price path step generator: configuration bank,
// controller and datapath. Depends on ppsg_pkg, ppsg_if, ppsg_cfg,
// ppsg_ctrl and ppsg_dp.

// Each sample produces one price step on the result channel. Items are
// processed one at a time, and a geometric-mode step takes longest: it runs
// the seven-term series for exp(), each term a product, round, reciprocal
// multiply and correction in turn on the single shared 34x34 multiplier. A
// finished result sits in the output register, so the next sample is taken
// while it waits; a new result waits only if the previous one has still not
// been transferred. Configuration writes take effect at once and must be made
// while no step is in flight.
module price_path_step_generator_top (
    input  logic        clk,
    input  logic        rst_n,
    ppsg_cfg_if.sink    cfg,
    ppsg_in_if.sink     sample,
    ppsg_out_if.source  result
);
    import ppsg_pkg::*;

    ppsg_cfg_t  cfg_q;
    ppsg_cmd_t  cmd;
    ppsg_stat_t stat;

    // Configuration registers
    ppsg_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    // Sequencer
    ppsg_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (sample.valid),
        .in_restart (sample.restart),
        .in_ready   (sample.ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    // Arithmetic and output register
    ppsg_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_q    (cfg_q),
        .z_sample (sample.z_sample),
        .cmd      (cmd),
        .stat     (stat),
        .result   (result)
    );

endmodule
